>>> src/lrc_pkg.sv
`timescale 1ns / 1ps
// Lighting request controller package: request and result structs, the
// configuration bundle, register indexes and fixed codes. No dependencies.
package lrc_pkg;

	// Field widths
	localparam int DT_W      = 16;
	localparam int HOUR_W    = 5;
	localparam int MODE_W    = 2;
	localparam int OVR_W     = 2;
	localparam int MINUTES_W = 11;
	localparam int LINGER_W  = 27;
	localparam int ELAPSED_W = 28;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 11;

	localparam logic [DT_W-1:0] MS_PER_MINUTE = 16'd60000;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_MODE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DOOR_ENABLE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_END   = 3'd4;

	// Base modes
	localparam logic [MODE_W-1:0] MODE_OFF    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ON     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DAY    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_WINDOW = 2'd3;

	// Override codes
	localparam logic [OVR_W-1:0] OVR_AUTO = 2'd0;
	localparam logic [OVR_W-1:0] OVR_ON   = 2'd1;
	localparam logic [OVR_W-1:0] OVR_OFF  = 2'd2;

	// Reset values of the window hours
	localparam logic [HOUR_W-1:0] WINDOW_START_RST = 5'd6;
	localparam logic [HOUR_W-1:0] WINDOW_END_RST   = 5'd22;

	typedef struct packed {
		logic [DT_W-1:0]   elapsed_ms;
		logic [HOUR_W-1:0] hour_now;
		logic              is_night;
		logic              door_sensor;
		logic              override_write;
		logic [OVR_W-1:0]  override_value;
		logic              lamp_feedback;
	} lrc_in_t;

	typedef struct packed {
		logic             light_request;
		logic             request_changed;
		logic [OVR_W-1:0] override_now;
		logic             override_expired;
		logic             lamp_state;
		logic             lamp_changed;
	} lrc_out_t;

	// Settings as the core sees them; the timeout is kept in milliseconds
	typedef struct packed {
		logic [MODE_W-1:0]   base_mode;
		logic                door_enable;
		logic [LINGER_W-1:0] limit_ms;
		logic [HOUR_W-1:0]   window_start;
		logic [HOUR_W-1:0]   window_end;
	} lrc_cfg_t;

endpackage

>>> src/lrc_core.sv
`timescale 1ns / 1ps
// Lighting request controller core: linger, override and last-value state
// with the per-request next-state and priority logic. Uses lrc_pkg.
module lrc_core
	import lrc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  lrc_cfg_t cfg,
	input  lrc_in_t  item,
	output lrc_out_t result
);

	logic [LINGER_W-1:0]  linger_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic [OVR_W-1:0]     ovr_q;
	logic                 last_req_q;
	logic                 last_lamp_q;

	logic                 door_forced;
	logic                 limit_nz;
	logic [OVR_W-1:0]     ovr_written;
	logic [OVR_W-1:0]     ovr_next;
	logic [LINGER_W-1:0]  dt_ext;
	logic [LINGER_W-1:0]  linger_next;
	logic [ELAPSED_W:0]   elapsed_sum;
	logic [ELAPSED_W-1:0] elapsed_add;
	logic [ELAPSED_W-1:0] elapsed_next;
	logic                 expired;
	logic                 in_window;
	logic                 base_req;
	logic                 req;

	assign door_forced = cfg.door_enable & item.door_sensor;
	assign limit_nz    = cfg.limit_ms != '0;
	assign dt_ext      = {{(LINGER_W-DT_W){1'b0}}, item.elapsed_ms};

	// Take a new override unless the code is undefined
	always_comb begin
		if (item.override_write && (item.override_value == OVR_AUTO ||
				item.override_value == OVR_ON || item.override_value == OVR_OFF)) begin
			ovr_written = item.override_value;
		end else begin
			ovr_written = ovr_q;
		end
	end

	// Reload linger while the door is open, else run it down to zero
	always_comb begin
		if (door_forced) begin
			linger_next = cfg.limit_ms;
		end else if (linger_q > dt_ext) begin
			linger_next = linger_q - dt_ext;
		end else begin
			linger_next = '0;
		end
	end

	// Advance override time and drop back to automatic on timeout
	assign elapsed_sum = {1'b0, elapsed_q} + {{(ELAPSED_W+1-DT_W){1'b0}}, item.elapsed_ms};
	assign elapsed_add = elapsed_sum[ELAPSED_W-1:0];

	always_comb begin
		ovr_next     = ovr_written;
		elapsed_next = elapsed_q;
		expired      = 1'b0;
		if (ovr_written != OVR_AUTO) begin
			if (limit_nz) begin
				if (elapsed_add >= {1'b0, cfg.limit_ms}) begin
					ovr_next     = OVR_AUTO;
					elapsed_next = '0;
					expired      = 1'b1;
				end else begin
					elapsed_next = elapsed_add;
				end
			end
		end else begin
			elapsed_next = '0;
		end
	end

	// Schedule window; wraps past midnight when start is above end
	always_comb begin
		if (cfg.window_start == cfg.window_end) begin
			in_window = 1'b0;
		end else if (cfg.window_start < cfg.window_end) begin
			in_window = (item.hour_now >= cfg.window_start) &&
				(item.hour_now < cfg.window_end);
		end else begin
			in_window = (item.hour_now >= cfg.window_start) ||
				(item.hour_now < cfg.window_end);
		end
	end

	always_comb begin
		case (cfg.base_mode)
			MODE_ON:     base_req = 1'b1;
			MODE_DAY:    base_req = ~item.is_night;
			MODE_WINDOW: base_req = in_window;
			default:     base_req = 1'b0;
		endcase
	end

	// Resolve priority: override, open door, linger, base mode
	always_comb begin
		case (ovr_next)
			OVR_ON:  req = 1'b1;
			OVR_OFF: req = 1'b0;
			default: req = door_forced | (linger_next != '0) | base_req;
		endcase
	end

	assign result.light_request    = req;
	assign result.request_changed  = req ^ last_req_q;
	assign result.override_now     = ovr_next;
	assign result.override_expired = expired;
	assign result.lamp_state       = item.lamp_feedback;
	assign result.lamp_changed     = item.lamp_feedback ^ last_lamp_q;

	// Commit state once per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			linger_q    <= '0;
			elapsed_q   <= '0;
			ovr_q       <= OVR_AUTO;
			last_req_q  <= 1'b0;
			last_lamp_q <= 1'b0;
		end else if (step) begin
			linger_q    <= linger_next;
			elapsed_q   <= elapsed_next;
			ovr_q       <= ovr_next;
			last_req_q  <= req;
			last_lamp_q <= item.lamp_feedback;
		end
	end

endmodule

>>> src/lighting_request_controller.sv
`timescale 1ns / 1ps
// Lighting request controller top level: input and result registers,
// configuration registers and the core. Uses lrc_pkg and lrc_core.
//
//  channel  | signals                               | direction
//  ---------+---------------------------------------+----------
//  in       | in_valid, in_ready, in_data           | request in
//  out      | out_valid, out_ready, out_data        | result out
//  cfg      | cfg_valid, cfg_ready, cfg_index/data  | register write
//
// One request per cycle sustained unless the output stalls; a request waits in
// the input register, then its result enters the result register, out_valid high.
// All state updates for a request happen in the single cycle it moves from
// the input register into the result register. A stalled output holds the
// result register and, once the input register is full too, drops in_ready. Reset
// clears valid and core state, loads register defaults; cfg_ready is always high.
module lighting_request_controller
	import lrc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  lrc_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output lrc_out_t              out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	lrc_in_t  item_s1;
	logic     valid_s1;
	lrc_out_t out_data_q;
	logic     out_valid_q;
	lrc_cfg_t cfg_q;
	lrc_out_t result;
	logic     advance;
	logic     cfg_wr;
	logic [LINGER_W-1:0] limit_new;

	assign advance   = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready  = ~valid_s1 | advance;
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Timeout in milliseconds, worked out once at write time
	assign limit_new = {{(LINGER_W-MINUTES_W){1'b0}}, cfg_data[MINUTES_W-1:0]} *
		{{(LINGER_W-DT_W){1'b0}}, MS_PER_MINUTE};

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_mode    <= MODE_OFF;
			cfg_q.door_enable  <= 1'b0;
			cfg_q.limit_ms     <= '0;
			cfg_q.window_start <= WINDOW_START_RST;
			cfg_q.window_end   <= WINDOW_END_RST;
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_BASE_MODE:    cfg_q.base_mode    <= cfg_data[MODE_W-1:0];
				CFG_DOOR_ENABLE:  cfg_q.door_enable  <= cfg_data[0];
				CFG_TIMEOUT:      cfg_q.limit_ms     <= limit_new;
				CFG_WINDOW_START: cfg_q.window_start <= cfg_data[HOUR_W-1:0];
				CFG_WINDOW_END:   cfg_q.window_end   <= cfg_data[HOUR_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register: hold the request until the result slot frees up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	lrc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.cfg    (cfg_q),
		.item   (item_s1),
		.result (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= result;
		end
	end

endmodule

>>> verif/lighting_request_controller_test.sv
`timescale 1ns / 1ps
// Testbench for lighting_request_controller: a directed table of ticks, then random
// ticks under changing settings and idle patterns, every result checked against a local
// controller model or a fixed table entry. Depends on lrc_pkg and the controller RTL.
module lighting_request_controller_test;
	import lrc_pkg::*;

	// Override code the controller must ignore
	localparam logic [OVR_W-1:0] OVR_INVALID = 2'd3;
	localparam lrc_out_t NO_RESULT = '0;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_CHUNKS = 5;
	localparam int CHUNK_TICKS  = 55;

	typedef struct packed {
		logic [MODE_W-1:0]    base_mode;
		logic                 door_enable;
		logic [MINUTES_W-1:0] timeout_min;
		logic [HOUR_W-1:0]    window_start;
		logic [HOUR_W-1:0]    window_end;
	} settings_t;

	typedef struct {
		settings_t setup;
		lrc_in_t   tick;
		bit        fixed;
		lrc_out_t  result;
	} tick_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	lrc_in_t               in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	lrc_out_t              out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Model state: register shadow and controller state
	settings_t             active_set;
	logic [LINGER_W-1:0]   linger_ms;
	logic [ELAPSED_W-1:0]  override_ms;
	logic [OVR_W-1:0]      override_mode;
	logic                  last_request;
	logic                  last_lamp;

	lrc_out_t  pending_results[$];
	tick_row_t directed_rows[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	int ticks_sent = 0;
	int results_checked = 0;
	int timeouts_seen = 0;
	int settings_applied = 0;
	int quiet_cycles = 0;

	lighting_request_controller i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Advance the model by one tick and return the result it should produce
	function automatic lrc_out_t resolve_light(lrc_in_t t);
		logic [31:0]       limit;
		logic              door_forced;
		logic [HOUR_W-1:0] first;
		logic [HOUR_W-1:0] stop;
		lrc_out_t          r;
		limit = 32'(active_set.timeout_min) * 32'(MS_PER_MINUTE);
		door_forced = active_set.door_enable && t.door_sensor;
		first = active_set.window_start;
		stop = active_set.window_end;
		r = '0;
		if (t.override_write && t.override_value != OVR_INVALID) begin
			override_mode = t.override_value;
		end
		// reload linger while the door is open, else run it down to zero
		if (door_forced) begin
			linger_ms = limit[LINGER_W-1:0];
		end else if (linger_ms != 0) begin
			linger_ms = (linger_ms > LINGER_W'(t.elapsed_ms)) ?
				linger_ms - LINGER_W'(t.elapsed_ms) : '0;
		end
		// age an active override and drop it back to automatic at the timeout
		if (override_mode != OVR_AUTO) begin
			if (limit != 0) begin
				override_ms = override_ms + ELAPSED_W'(t.elapsed_ms);
				if (32'(override_ms) >= limit) begin
					override_mode = OVR_AUTO;
					override_ms = '0;
					r.override_expired = 1'b1;
				end
			end
		end else begin
			override_ms = '0;
		end
		// resolve by priority: override, door, linger, base mode
		if (override_mode == OVR_ON) begin
			r.light_request = 1'b1;
		end else if (override_mode == OVR_OFF) begin
			r.light_request = 1'b0;
		end else if (door_forced || linger_ms != 0) begin
			r.light_request = 1'b1;
		end else begin
			case (active_set.base_mode)
				MODE_ON: r.light_request = 1'b1;
				MODE_DAY: r.light_request = !t.is_night;
				MODE_WINDOW: begin
					if (first == stop) r.light_request = 1'b0;
					else if (first < stop) r.light_request = t.hour_now >= first && t.hour_now < stop;
					else r.light_request = t.hour_now >= first || t.hour_now < stop;
				end
				default: r.light_request = 1'b0;
			endcase
		end
		r.request_changed = r.light_request != last_request;
		last_request = r.light_request;
		r.override_now = override_mode;
		r.lamp_state = t.lamp_feedback;
		r.lamp_changed = t.lamp_feedback != last_lamp;
		last_lamp = t.lamp_feedback;
		return r;
	endfunction

	function automatic void check_field(string name, logic [1:0] want, logic [1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Fields of a tick in package order: elapsed, hour, night, door, write, value, lamp
	function automatic void add_row(settings_t s, logic [DT_W-1:0] dt, logic [HOUR_W-1:0] hour,
			logic night, logic door, logic ovr_write, logic [OVR_W-1:0] ovr_value, logic lamp,
			bit fixed, lrc_out_t result);
		tick_row_t row;
		row.setup = s;
		row.tick = {dt, hour, night, door, ovr_write, ovr_value, lamp};
		row.fixed = fixed;
		row.result = result;
		directed_rows.push_back(row);
	endfunction

	// Offer one request after a random gap; record its expected result on acceptance
	task automatic send_tick(lrc_in_t t, bit fixed, lrc_out_t result);
		int       gap;
		lrc_out_t predicted;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 200) gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= t;
		do @(posedge clk); while (!in_ready);
		predicted = resolve_light(t);
		if (predicted.override_expired) timeouts_seen++;
		pending_results.push_back(fixed ? result : predicted);
		ticks_sent++;
	endtask

	// Hold off requests until every expected result has come back
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_BASE_MODE: active_set.base_mode = value[MODE_W-1:0];
			CFG_DOOR_ENABLE: active_set.door_enable = value[0];
			CFG_TIMEOUT: active_set.timeout_min = value[MINUTES_W-1:0];
			CFG_WINDOW_START: active_set.window_start = value[HOUR_W-1:0];
			CFG_WINDOW_END: active_set.window_end = value[HOUR_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(settings_t s);
		wait_idle();
		write_register(CFG_BASE_MODE, CFG_DATA_W'(s.base_mode));
		write_register(CFG_DOOR_ENABLE, CFG_DATA_W'(s.door_enable));
		write_register(CFG_TIMEOUT, CFG_DATA_W'(s.timeout_min));
		write_register(CFG_WINDOW_START, CFG_DATA_W'(s.window_start));
		write_register(CFG_WINDOW_END, CFG_DATA_W'(s.window_end));
		cfg_valid <= 1'b0;
		settings_applied++;
	endtask

	// Stall the result side at random and check each accepted result
	always @(posedge clk) begin : take_result
		lrc_out_t want;
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result arrived with no request pending");
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("light_request", 2'(want.light_request),
					2'(out_data.light_request));
				check_field("request_changed", 2'(want.request_changed),
					2'(out_data.request_changed));
				check_field("override_now", want.override_now, out_data.override_now);
				check_field("override_expired", 2'(want.override_expired),
					2'(out_data.override_expired));
				check_field("lamp_state", 2'(want.lamp_state), 2'(out_data.lamp_state));
				check_field("lamp_changed", 2'(want.lamp_changed), 2'(out_data.lamp_changed));
				results_checked++;
			end
		end
	end

	// End the run when no channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
				quiet_cycles, pending_results.size());
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		settings_t s;
		lrc_in_t   t;
		logic      door_level;
		logic      lamp_level;
		int        phase;
		int        chunk;
		int        n;
		door_level = 1'b0;
		lamp_level = 1'b0;
		active_set = {MODE_OFF, 1'b0, 11'd0, WINDOW_START_RST, WINDOW_END_RST};
		linger_ms = '0;
		override_ms = '0;
		override_mode = OVR_AUTO;
		last_request = 1'b0;
		last_lamp = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table; result fields: request, changed, override, expired, lamp, lamp changed
		s = active_set;
		add_row(s, 16'd0, 5'd0, 1'b0, 1'b0, 1'b0, OVR_AUTO, 1'b0,
			1, {1'b0, 1'b0, OVR_AUTO, 1'b0, 1'b0, 1'b0});
		// all fields at their top, ignored override code, door disabled
		add_row(s, 16'hFFFF, 5'd31, 1'b1, 1'b1, 1'b1, OVR_INVALID, 1'b1,
			1, {1'b0, 1'b0, OVR_AUTO, 1'b0, 1'b1, 1'b1});
		s.base_mode = MODE_ON;
		add_row(s, 16'd100, 5'd12, 1'b0, 1'b0, 1'b0, OVR_AUTO, 1'b0, 0, NO_RESULT);
		s.base_mode = MODE_DAY;
		add_row(s, 16'd100, 5'd12, 1'b1, 1'b0, 1'b0, OVR_AUTO, 1'b0, 0, NO_RESULT);
		add_row(s, 16'd100, 5'd12, 1'b0, 1'b0, 1'b0, OVR_AUTO, 1'b1, 0, NO_RESULT);
		// plain window edges
		s.base_mode = MODE_WINDOW;
		add_row(s, 16'd1, 5'd5, 1'b0, 1'b0, 1'b0, OVR_AUTO, 1'b1, 0, NO_RESULT);
		add_row(s, 16'd1, 5'd6, 1'b0, 1'b0, 1'b0, OVR_AUTO, 1'b0, 0, NO_RESULT);
		add_row(s, 16'd1, 5'd21, 1'b0, 1'b0, 1'b0, OVR_AUTO, 1'b0, 0, NO_RESULT);
		add_row(s, 16'd1, 5'd22, 1'b0, 1'b0, 1'b0, OVR_AUTO, 1'b0, 0, NO_RESULT);
		// window wrapping past midnight
		s.window_start = 5'd22;
		s.window_end = 5'd6;
		add_row(s, 16'd1, 5'd23, 1'b0, 1'b0, 1'b0, OVR_AUTO, 1'b0, 0, NO_RESULT);
		add_row(s, 16'd1, 5'd0, 1'b0, 1'b0, 1'b0, OVR_AUTO, 1'b0, 0, NO_RESULT);
		add_row(s, 16'd1, 5'd5, 1'b0, 1'b0, 1'b0, OVR_AUTO, 1'b0, 0, NO_RESULT);
		add_row(s, 16'd1, 5'd6, 1'b0, 1'b0, 1'b0, OVR_AUTO, 1'b0, 0, NO_RESULT);
		// empty window, then an hour past 23 against a late window
		s.window_start = 5'd10;
		s.window_end = 5'd10;
		add_row(s, 16'd1, 5'd10, 1'b0, 1'b0, 1'b0, OVR_AUTO, 1'b0, 0, NO_RESULT);
		s.window_start = 5'd20;
		s.window_end = 5'd23;
		add_row(s, 16'd1, 5'd27, 1'b0, 1'b0, 1'b0, OVR_AUTO, 1'b0, 0, NO_RESULT);
		// override switched while active keeps its age, then times out
		s = {MODE_OFF, 1'b0, 11'd1, WINDOW_START_RST, WINDOW_END_RST};
		add_row(s, 16'd30000, 5'd8, 1'b0, 1'b0, 1'b1, OVR_ON, 1'b1, 0, NO_RESULT);
		add_row(s, 16'd20000, 5'd8, 1'b0, 1'b0, 1'b1, OVR_OFF, 1'b1, 0, NO_RESULT);
		add_row(s, 16'd10000, 5'd8, 1'b0, 1'b0, 1'b0, OVR_AUTO, 1'b0, 0, NO_RESULT);
		// timeout disabled: override holds until cleared by hand
		s.timeout_min = 11'd0;
		add_row(s, 16'hFFFF, 5'd8, 1'b0, 1'b0, 1'b1, OVR_ON, 1'b0, 0, NO_RESULT);
		add_row(s, 16'hFFFF, 5'd8, 1'b0, 1'b0, 1'b0, OVR_AUTO, 1'b0, 0, NO_RESULT);
		add_row(s, 16'd0, 5'd8, 1'b0, 1'b0, 1'b1, OVR_AUTO, 1'b0, 0, NO_RESULT);
		// door with no timeout leaves no linger
		s.door_enable = 1'b1;
		add_row(s, 16'd0, 5'd8, 1'b0, 1'b1, 1'b0, OVR_AUTO, 1'b1, 0, NO_RESULT);
		add_row(s, 16'd1, 5'd8, 1'b0, 1'b0, 1'b0, OVR_AUTO, 1'b1, 0, NO_RESULT);
		// door with a one-day timeout lingers after closing
		s.timeout_min = 11'd1440;
		add_row(s, 16'd0, 5'd8, 1'b0, 1'b1, 1'b0, OVR_AUTO, 1'b0, 0, NO_RESULT);
		add_row(s, 16'hFFFF, 5'd8, 1'b0, 1'b0, 1'b0, OVR_AUTO, 1'b0, 0, NO_RESULT);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].setup != active_set) apply_settings(directed_rows[i].setup);
			send_tick(directed_rows[i].tick, directed_rows[i].fixed, directed_rows[i].result);
		end

		// Random ticks: four idle patterns, fresh settings every chunk
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 77; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 77; end
				default: begin send_idle_pct = 17; recv_stall_pct = 17; end
			endcase
			for (chunk = 0; chunk < PHASE_CHUNKS; chunk++) begin
				s.base_mode = MODE_W'($urandom_range(3));
				s.door_enable = 1'($urandom_range(1));
				// mostly short timeouts so overrides and linger expire often
				case ($urandom_range(7))
					0: s.timeout_min = 11'd0;
					1, 2: s.timeout_min = 11'd1;
					3: s.timeout_min = 11'd2;
					4: s.timeout_min = MINUTES_W'($urandom_range(20, 3));
					5: s.timeout_min = 11'd1440;
					6: s.timeout_min = 11'd2047;
					default: s.timeout_min = MINUTES_W'($urandom_range(2047));
				endcase
				s.window_start = HOUR_W'(($urandom_range(9) == 0) ?
					$urandom_range(31) : $urandom_range(23));
				s.window_end = HOUR_W'(($urandom_range(9) == 0) ?
					$urandom_range(31) : $urandom_range(23));
				if ($urandom_range(9) == 0) s.window_end = s.window_start;
				apply_settings(s);
				for (n = 0; n < CHUNK_TICKS; n++) begin
					if ($urandom_range(149) == 0) wait_idle();
					// door and lamp change now and then rather than every tick
					if ($urandom_range(3) == 0) door_level = !door_level;
					if ($urandom_range(3) == 0) lamp_level = !lamp_level;
					case ($urandom_range(7))
						0: t.elapsed_ms = '0;
						1: t.elapsed_ms = '1;
						2: t.elapsed_ms = DT_W'($urandom_range(255));
						default: t.elapsed_ms = DT_W'($urandom_range(16'hFFFF));
					endcase
					t.hour_now = HOUR_W'(($urandom_range(9) == 0) ?
						$urandom_range(31) : $urandom_range(23));
					t.is_night = 1'($urandom_range(1));
					t.door_sensor = door_level;
					t.override_write = ($urandom_range(5) == 0);
					t.override_value = OVR_W'($urandom_range(3));
					t.lamp_feedback = lamp_level;
					send_tick(t, 0, NO_RESULT);
				end
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d ticks and checked %0d results across %0d register settings,",
			ticks_sent, results_checked, settings_applied);
		$display("four idle patterns and %0d override timeouts.", timeouts_seen);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

>>> filelist.f
src/lrc_pkg.sv
src/lrc_core.sv
src/lighting_request_controller.sv
verif/lighting_request_controller_test.sv
